// ===== rtl/core/led_fcs_pkg.sv =====
package led_fcs_pkg;

  localparam int COLOR_W = 24;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic               overlay_mode;
  } in_t;

  typedef struct packed {
    logic [COLOR_W-1:0] out_color;
    logic               frame_last;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_SEND_RD,
    S_SEND_LOAD,
    S_SEND_WAIT
  } state_t;

endpackage

// ===== rtl/core/led_frame_change_sender.sv =====
// Channel  Ports                         Direction  Moves
// -------  ----------------------------  ---------  ------------------------------
// in       in_valid, in_ready, in_data   input      one pixel request (color, overlay)
// out      out_valid, out_ready, out_data output    one pixel of a sent frame
//
// Each input pixel is accepted in S_IDLE, which reads the shown-frame memory
// at the write position; S_WRITE then resolves overlay, writes staging memory
// and folds the compare into a running change flag. A changed frame then
// streams out: S_SEND_RD reads the staging memory, then each pixel is loaded
// into the output register in S_SEND_LOAD and offered in S_SEND_WAIT. Reset
// is synchronous; the shown frame reads as zero until the first frame is
// sent, so no clearing pass is needed. Input is not taken while a frame is
// being sent; a stalled out_ready holds the current pixel.
module led_frame_change_sender #(
  parameter int FRAME_PIXELS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  led_fcs_pkg::in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output led_fcs_pkg::out_t  out_data
);
  import led_fcs_pkg::*;

  localparam int IDX_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_PIXELS - 1);

  logic [COLOR_W-1:0] staging_mem [FRAME_PIXELS];
  logic [COLOR_W-1:0] shown_mem   [FRAME_PIXELS];
  logic [COLOR_W-1:0] staging_q;
  logic [COLOR_W-1:0] shown_q;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             diff_r, diff_nxt;
  logic             shown_valid_r, shown_valid_nxt;
  in_t              hold_r;
  out_t             out_r;

  logic [COLOR_W-1:0] shown_eff;
  logic [COLOR_W-1:0] pix_val;
  logic               frame_diff;
  logic [IDX_W-1:0]   rd_idx;
  logic               in_acc;
  logic               out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // shown frame is all zeros until the first frame goes out
  assign shown_eff = shown_valid_r ? shown_q : '0;
  assign pix_val   = (hold_r.overlay_mode && (hold_r.pixel_color == '0)) ?
                     shown_eff : hold_r.pixel_color;
  assign frame_diff = ((pos_r != '0) && diff_r) || (pix_val != shown_eff);

  // prefetch the next staging pixel while the current one waits
  assign rd_idx = (state_r == S_SEND_WAIT && idx_r != LAST_IDX) ?
                  idx_r + IDX_W'(1) : idx_r;

  always_ff @(posedge clk) begin
    shown_q <= shown_mem[pos_r];
    if (state_r == S_SEND_LOAD) begin
      shown_mem[idx_r] <= staging_q;
    end
  end

  always_ff @(posedge clk) begin
    staging_q <= staging_mem[rd_idx];
    if (state_r == S_WRITE) begin
      staging_mem[pos_r] <= pix_val;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (pos_r == LAST_IDX && frame_diff) state_nxt = S_SEND_RD;
        else state_nxt = S_IDLE;
      end
      S_SEND_RD:   state_nxt = S_SEND_LOAD;
      S_SEND_LOAD: state_nxt = S_SEND_WAIT;
      S_SEND_WAIT: begin
        if (out_acc) state_nxt = (idx_r == LAST_IDX) ? S_IDLE : S_SEND_LOAD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    pos_nxt         = pos_r;
    idx_nxt         = idx_r;
    diff_nxt        = diff_r;
    shown_valid_nxt = shown_valid_r;
    unique case (state_r)
      S_WRITE: begin
        diff_nxt = frame_diff;
        pos_nxt  = (pos_r == LAST_IDX) ? '0 : pos_r + IDX_W'(1);
        idx_nxt  = '0;
      end
      S_SEND_WAIT: begin
        if (out_acc) begin
          if (idx_r == LAST_IDX) shown_valid_nxt = 1'b1;
          else idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      pos_r         <= '0;
      idx_r         <= '0;
      diff_r        <= 1'b0;
      shown_valid_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pos_r         <= pos_nxt;
      idx_r         <= idx_nxt;
      diff_r        <= diff_nxt;
      shown_valid_r <= shown_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) hold_r <= in_data;
    if (state_r == S_SEND_LOAD) begin
      out_r.out_color  <= staging_q;
      out_r.frame_last <= (idx_r == LAST_IDX);
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_SEND_WAIT);
  assign out_data  = out_r;

endmodule

// ===== tb/led_frame_change_sender_test.sv =====
`timescale 1ns / 1ps

module led_frame_change_sender_test;
  import led_fcs_pkg::*;

  localparam int FRAME_PIXELS = 16;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 3 * FRAME_PIXELS + 8;

  typedef enum int {
    FRAME_RANDOM,
    FRAME_KEEP_ALL,
    FRAME_ONE_CHANGE,
    FRAME_REPEAT
  } frame_style_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  led_frame_change_sender #(
    .FRAME_PIXELS(FRAME_PIXELS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the block's frames
  logic [COLOR_W-1:0] shown_px [FRAME_PIXELS];
  logic [COLOR_W-1:0] staged_px[FRAME_PIXELS];
  int                 next_pos;

  out_t pending_pixels[$];
  int   send_idle_pct;
  int   recv_idle_pct;
  int   error_count = 0;
  int   frames_sent;
  int   frames_held;
  int   pixels_checked = 0;
  int   cycle_count = 0;

  // Apply one accepted pixel; queue the whole frame if it differs from the shown one.
  task automatic stage_pixel(input in_t req);
    logic changed;
    out_t px;
    changed = 1'b0;
    if (req.overlay_mode && req.pixel_color == '0) begin
      staged_px[next_pos] = shown_px[next_pos];
    end else begin
      staged_px[next_pos] = req.pixel_color;
    end
    if (next_pos == FRAME_PIXELS - 1) begin
      next_pos = 0;
      for (int i = 0; i < FRAME_PIXELS; i++) begin
        if (staged_px[i] != shown_px[i]) changed = 1'b1;
      end
      if (changed) begin
        for (int i = 0; i < FRAME_PIXELS; i++) begin
          px.out_color  = staged_px[i];
          px.frame_last = (i == FRAME_PIXELS - 1);
          pending_pixels.push_back(px);
          shown_px[i] = staged_px[i];
        end
        frames_sent++;
      end else begin
        frames_held++;
      end
    end else begin
      next_pos++;
    end
  endtask

  // Called just after a rising edge; returns just after the edge that took the request.
  task automatic offer_pixel(input logic [COLOR_W-1:0] color, input logic overlay);
    in_t req;
    req.pixel_color  = color;
    req.overlay_mode = overlay;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    stage_pixel(req);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel color=%h last=%b", $time,
                 out_data.out_color, out_data.frame_last);
        error_count++;
      end else begin
        if (out_data.out_color !== pending_pixels[0].out_color) begin
          $display("%0t: out_color expected %h actual %h", $time,
                   pending_pixels[0].out_color, out_data.out_color);
          error_count++;
        end
        if (out_data.frame_last !== pending_pixels[0].frame_last) begin
          $display("%0t: frame_last expected %b actual %b", $time,
                   pending_pixels[0].frame_last, out_data.frame_last);
          error_count++;
        end
        void'(pending_pixels.pop_front());
        pixels_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels outstanding", cycle_count,
               pending_pixels.size());
      $display("FAIL led_frame_change_sender");
      $finish;
    end
  end

  // Zero and full-scale colors, single bits, overlay on zero and nonzero.
  task automatic test_extreme_pixels();
    logic [COLOR_W-1:0] colors[FRAME_PIXELS] = '{
      24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
      24'h800000, 24'h000001, 24'hFF0000, 24'h00FF00,
      24'h0000FF, 24'hAAAAAA, 24'h555555, 24'h7FFFFF,
      24'h123456, 24'hFEDCBA, 24'h000000, 24'h010203
    };
    logic [FRAME_PIXELS-1:0] overlays = 16'b0101_0000_0000_1100;
    for (int p = 0; p < FRAME_PIXELS; p++) offer_pixel(colors[p], overlays[p]);
  endtask

  // All overlay zeros keep the shown frame, so nothing goes out.
  task automatic test_unchanged_frame();
    for (int p = 0; p < FRAME_PIXELS; p++) offer_pixel('0, 1'b1);
  endtask

  task automatic test_random_frames(input int send_pct, input int recv_pct, input int frames);
    frame_style_t style;
    int           hit;
    logic [COLOR_W-1:0] color;
    logic         overlay;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int f = 0; f < frames; f++) begin
      style = (f == 0) ? FRAME_RANDOM : frame_style_t'($urandom_range(0, 3));
      hit   = $urandom_range(0, FRAME_PIXELS - 1);
      for (int p = 0; p < FRAME_PIXELS; p++) begin
        case (style)
          FRAME_RANDOM: begin
            color   = ($urandom_range(0, 7) == 0) ? '0 : COLOR_W'($urandom);
            overlay = 1'($urandom_range(0, 1));
          end
          FRAME_KEEP_ALL: begin
            color   = '0;
            overlay = 1'b1;
          end
          FRAME_ONE_CHANGE: begin
            if (p == hit) begin
              color   = COLOR_W'($urandom);
              overlay = 1'($urandom_range(0, 1));
            end else if ($urandom_range(0, 1)) begin
              color   = '0;
              overlay = 1'b1;
            end else begin
              color   = shown_px[p];
              overlay = 1'b0;
            end
          end
          default: begin
            color   = shown_px[p];
            overlay = 1'($urandom_range(0, 1));
          end
        endcase
        offer_pixel(color, overlay);
      end
    end
  endtask

  initial begin
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    frames_sent    = 0;
    frames_held    = 0;
    next_pos       = 0;
    for (int i = 0; i < FRAME_PIXELS; i++) begin
      shown_px[i]  = '0;
      staged_px[i] = '0;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 21;
    recv_idle_pct = 83;
    test_extreme_pixels();
    test_unchanged_frame();
    test_random_frames(21, 83, 2);
    test_random_frames(83, 21, 2);
    test_random_frames(0, 0, 2);

    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_pixels.size() != 0) begin
      $display("%0d expected pixels never arrived", pending_pixels.size());
    end
    $display("frames sent %0d, unchanged frames held back %0d, pixels checked %0d",
             frames_sent, frames_held, pixels_checked);
    $display("idle mixes: sender-light/receiver-heavy, the reverse, and none");
    if (error_count == 0 && pending_pixels.size() == 0) begin
      $display("PASS led_frame_change_sender");
    end else begin
      $display("FAIL led_frame_change_sender");
    end
    $finish;
  end

endmodule
